### src/assert_macros.svh
// Assertion helpers used by the parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/cclp_pkg.sv
`default_nettype none

package cclp_pkg;

	// Default key length limit
	localparam int MAX_KEY_CHARS_DEF = 8;

	localparam int NUM_KW = 16;
	localparam int KW_TEXT_W = 112;
	localparam logic [2:0] PREFIX_LEN = 3'd5;
	localparam logic [3:0] SET_HDR_LEN = 4'd4;
	localparam logic [16:0] VALUE_MAX = 17'd65535;
	localparam logic [16:0] VALUE_CLAMP = 17'd65536;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;

	// Frame status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOCMD = 2'd1;
	localparam logic [1:0] ST_BADFRAME = 2'd2;
	localparam logic [1:0] ST_BADSUM = 2'd3;

	// Command codes
	localparam logic [3:0] CMD_UNKNOWN = 4'd0;
	localparam logic [3:0] CMD_STAT = 4'd1;
	localparam logic [3:0] CMD_CFG = 4'd2;
	localparam logic [3:0] CMD_LOG = 4'd3;
	localparam logic [3:0] CMD_CLRLOG = 4'd4;
	localparam logic [3:0] CMD_SET = 4'd5;
	localparam logic [3:0] CMD_SAVE = 4'd6;
	localparam logic [3:0] CMD_DEFAULT = 4'd7;
	localparam logic [3:0] CMD_MODE_LITE = 4'd8;
	localparam logic [3:0] CMD_DEMO_ON = 4'd9;
	localparam logic [3:0] CMD_DEMO_OFF = 4'd10;
	localparam logic [3:0] CMD_MODE_PRO = 4'd11;

	typedef enum logic [4:0] {
		PH_SKIP   = 5'b00001,
		PH_PREFIX = 5'b00010,
		PH_BODY   = 5'b00100,
		PH_HEX    = 5'b01000,
		PH_DEAD   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic notset;
		logic eq;
		logic vbad;
		logic vdigit;
	} set_flags_t;

	// Per-line running state (key storage kept apart, its width is a parameter)
	typedef struct packed {
		phase_t      phase;
		logic [2:0]  prefix_index;
		logic [7:0]  xor_sum;
		logic [1:0]  hex_count;
		logic [7:0]  received_sum;
		logic        hex_error;
		logic [15:0] keyword_alive;
		logic [3:0]  body_position;
		logic [16:0] value_acc;
		set_flags_t  flags;
	} line_state_t;

	typedef struct packed {
		logic [1:0]  frame_status;
		logic [3:0]  command_code;
		logic [63:0] set_key;
		logic [3:0]  set_key_length;
		logic [15:0] set_value;
	} result_t;

	function automatic line_state_t state_reset();
		line_state_t s;
		s.phase = PH_SKIP;
		s.prefix_index = '0;
		s.xor_sum = '0;
		s.hex_count = '0;
		s.received_sum = '0;
		s.hex_error = 1'b0;
		s.keyword_alive = '1;
		s.body_position = '0;
		s.value_acc = '0;
		s.flags = '0;
		return s;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = "@";
			3'd1: ch = "C";
			3'd2: ch = "M";
			3'd3: ch = "D";
			3'd4: ch = ",";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] set_char(input logic [1:0] idx);
		logic [7:0] ch;
		unique case (idx)
			2'd0: ch = "S";
			2'd1: ch = "E";
			2'd2: ch = "T";
			default: ch = ",";
		endcase
		return ch;
	endfunction

	// {error, nibble}; an invalid digit gives nibble F with the error bit set
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		if (c >= "0" && c <= "9") begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= "A" && c <= "F") begin
			r = {1'b0, 4'(c - 8'h37)};
		end else if (c >= "a" && c <= "f") begin
			r = {1'b0, 4'(c - 8'h57)};
		end else begin
			r = 5'h1F;
		end
		return r;
	endfunction

	// Keyword text, right aligned: last character in the low byte
	function automatic logic [KW_TEXT_W-1:0] kw_text(input logic [3:0] k);
		logic [KW_TEXT_W-1:0] t;
		unique case (k)
			4'd0:  t = KW_TEXT_W'("STAT?");
			4'd1:  t = KW_TEXT_W'("CFG?");
			4'd2:  t = KW_TEXT_W'("LOG?");
			4'd3:  t = KW_TEXT_W'("CLRLOG");
			4'd4:  t = KW_TEXT_W'("LOGCLR");
			4'd5:  t = KW_TEXT_W'("SAVE");
			4'd6:  t = KW_TEXT_W'("RESET");
			4'd7:  t = KW_TEXT_W'("DEFAULT");
			4'd8:  t = KW_TEXT_W'({"MODE=PRO", "_LITE"});
			4'd9:  t = KW_TEXT_W'("MODE=LITE");
			4'd10: t = KW_TEXT_W'("DEMO=1");
			4'd11: t = KW_TEXT_W'("DEMO=ON");
			4'd12: t = KW_TEXT_W'("DEMO=0");
			4'd13: t = KW_TEXT_W'("DEMO=OFF");
			4'd14: t = KW_TEXT_W'("MODE=PRO");
			default: t = KW_TEXT_W'("MODE=BASIC");
		endcase
		return t;
	endfunction

	function automatic logic [3:0] kw_len(input logic [3:0] k);
		logic [3:0] n;
		unique case (k)
			4'd0, 4'd6: n = 4'd5;
			4'd1, 4'd2, 4'd5: n = 4'd4;
			4'd3, 4'd4, 4'd10, 4'd12: n = 4'd6;
			4'd7, 4'd11: n = 4'd7;
			4'd8: n = 4'd13;
			4'd9: n = 4'd9;
			4'd13, 4'd14: n = 4'd8;
			default: n = 4'd10;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] kw_code(input logic [3:0] k);
		logic [3:0] c;
		unique case (k)
			4'd0: c = CMD_STAT;
			4'd1: c = CMD_CFG;
			4'd2: c = CMD_LOG;
			4'd3, 4'd4: c = CMD_CLRLOG;
			4'd5: c = CMD_SAVE;
			4'd6, 4'd7: c = CMD_DEFAULT;
			4'd8, 4'd9: c = CMD_MODE_LITE;
			4'd10, 4'd11: c = CMD_DEMO_ON;
			4'd12, 4'd13: c = CMD_DEMO_OFF;
			default: c = CMD_MODE_PRO;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### src/cclp_step.sv
`default_nettype none

// Next-state logic for one byte of the line
module cclp_step #(
	parameter int MAX_KEY_CHARS = cclp_pkg::MAX_KEY_CHARS_DEF,
	parameter int KEY_W = 8 * MAX_KEY_CHARS,
	parameter int KCW = $clog2(MAX_KEY_CHARS + 2)
) (
	input  wire cclp_pkg::line_state_t st,
	input  wire logic [KEY_W-1:0]      key_shift,
	input  wire logic [KCW-1:0]        key_count,
	input  wire logic [7:0]            char_in,
	output cclp_pkg::line_state_t      st_n,
	output logic [KEY_W-1:0]           key_shift_n,
	output logic [KCW-1:0]             key_count_n
);

	logic [15:0] alive_n;
	logic [4:0]  hx;
	logic [19:0] acc_w;
	logic [3:0]  digit;

	// Keyword survivors after this body byte
	always_comb begin
		logic [cclp_pkg::KW_TEXT_W-1:0] t;
		logic [3:0] len;
		logic [3:0] idx;
		for (int k = 0; k < cclp_pkg::NUM_KW; k++) begin
			t = cclp_pkg::kw_text(4'(k));
			len = cclp_pkg::kw_len(4'(k));
			idx = len - 4'd1 - st.body_position;
			alive_n[k] = st.keyword_alive[k] && (st.body_position < len)
				&& (t[{idx, 3'b000} +: 8] == char_in);
		end
	end

	// Decimal accumulate: acc * 10 + digit
	assign digit = 4'(char_in - cclp_pkg::CH_0);
	assign acc_w = {st.value_acc, 3'b000} + {2'b00, st.value_acc, 1'b0} + 20'(digit);
	assign hx = cclp_pkg::hex_val(char_in);

	always_comb begin
		cclp_pkg::phase_t ph;
		st_n = st;
		key_shift_n = key_shift;
		key_count_n = key_count;
		ph = st.phase;
		if (ph == cclp_pkg::PH_SKIP && char_in != cclp_pkg::CH_SPACE
				&& char_in != cclp_pkg::CH_TAB) begin
			ph = cclp_pkg::PH_PREFIX;
		end
		st_n.phase = ph;
		unique case (ph)
			cclp_pkg::PH_PREFIX: begin
				if (st.prefix_index < cclp_pkg::PREFIX_LEN
						&& char_in == cclp_pkg::prefix_char(st.prefix_index)) begin
					st_n.xor_sum = st.xor_sum ^ char_in;
					st_n.prefix_index = st.prefix_index + 3'd1;
					if (st_n.prefix_index == cclp_pkg::PREFIX_LEN) begin
						st_n.phase = cclp_pkg::PH_BODY;
					end
				end else begin
					st_n.phase = cclp_pkg::PH_DEAD;
				end
			end
			cclp_pkg::PH_BODY: begin
				if (char_in == cclp_pkg::CH_STAR) begin
					st_n.phase = cclp_pkg::PH_HEX;
				end else begin
					st_n.xor_sum = st.xor_sum ^ char_in;
					st_n.keyword_alive = alive_n;
					// SET,key=value field tracking
					if (st.body_position < cclp_pkg::SET_HDR_LEN) begin
						if (char_in != cclp_pkg::set_char(st.body_position[1:0])) begin
							st_n.flags.notset = 1'b1;
						end
					end else if (!st.flags.eq) begin
						if (char_in == cclp_pkg::CH_EQ) begin
							st_n.flags.eq = 1'b1;
						end else if (key_count <= KCW'(MAX_KEY_CHARS)) begin
							key_count_n = key_count + KCW'(1);
							if (key_count_n <= KCW'(MAX_KEY_CHARS)) begin
								key_shift_n = (key_shift << 8) | KEY_W'(char_in);
							end
						end
					end else begin
						if (char_in >= cclp_pkg::CH_0 && char_in <= cclp_pkg::CH_9) begin
							st_n.flags.vdigit = 1'b1;
							if (acc_w > 20'(cclp_pkg::VALUE_MAX)) begin
								st_n.flags.vbad = 1'b1;
								st_n.value_acc = cclp_pkg::VALUE_CLAMP;
							end else begin
								st_n.value_acc = acc_w[16:0];
							end
						end else begin
							st_n.flags.vbad = 1'b1;
						end
					end
					// Body length saturates at 15
					if (st.body_position != 4'hF) begin
						st_n.body_position = st.body_position + 4'd1;
					end
				end
			end
			cclp_pkg::PH_HEX: begin
				if (st.hex_count < 2'd2) begin
					if (hx[4]) begin
						st_n.hex_error = 1'b1;
					end
					st_n.received_sum = {st.received_sum[3:0], hx[3:0]};
					st_n.hex_count = st.hex_count + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### src/cclp_eval.sv
`default_nettype none

// End-of-line evaluation: frame checks, keyword pick and SET validation
module cclp_eval #(
	parameter int MAX_KEY_CHARS = cclp_pkg::MAX_KEY_CHARS_DEF,
	parameter int KEY_W = 8 * MAX_KEY_CHARS,
	parameter int KCW = $clog2(MAX_KEY_CHARS + 2)
) (
	input  wire cclp_pkg::line_state_t st,
	input  wire logic [KEY_W-1:0]      key_shift,
	input  wire logic [KCW-1:0]        key_count,
	output cclp_pkg::result_t          res
);

	logic            set_ok;
	logic [3:0]      kw_hit;
	cclp_pkg::result_t body_res;

	assign set_ok = (st.body_position >= cclp_pkg::SET_HDR_LEN) && !st.flags.notset
		&& st.flags.eq && (key_count != '0) && (key_count <= KCW'(MAX_KEY_CHARS))
		&& st.flags.vdigit && !st.flags.vbad;

	// First surviving keyword whose length equals the body length
	always_comb begin
		logic found;
		found = 1'b0;
		kw_hit = cclp_pkg::CMD_UNKNOWN;
		for (int k = 0; k < cclp_pkg::NUM_KW; k++) begin
			if (!found && st.keyword_alive[k]
					&& st.body_position == cclp_pkg::kw_len(4'(k))) begin
				kw_hit = cclp_pkg::kw_code(4'(k));
				found = 1'b1;
			end
		end
	end

	always_comb begin
		body_res = '0;
		body_res.frame_status = cclp_pkg::ST_OK;
		if (set_ok) begin
			body_res.command_code = cclp_pkg::CMD_SET;
			body_res.set_key = 64'(key_shift);
			body_res.set_key_length = 4'(key_count);
			body_res.set_value = st.value_acc[15:0];
		end else begin
			body_res.command_code = kw_hit;
		end
	end

	always_comb begin
		res = '0;
		if (st.phase == cclp_pkg::PH_BODY) begin
			res = body_res;
		end else if (st.phase == cclp_pkg::PH_HEX) begin
			if (st.hex_count < 2'd2) begin
				res.frame_status = cclp_pkg::ST_BADFRAME;
			end else if (st.hex_error || st.received_sum != st.xor_sum) begin
				res.frame_status = cclp_pkg::ST_BADSUM;
			end else begin
				res = body_res;
			end
		end else begin
			res.frame_status = cclp_pkg::ST_NOCMD;
		end
	end

endmodule

`default_nettype wire

### src/checked_command_line_parser_core.sv
// Data path: the last byte of a line is taken into the input register, then next-state/evaluation
// logic loads its result into the result (output) register, unless a held result stalls it.
// Throughput: one byte per cycle; input stalls only when a last byte meets a held result.
// Reset: arst_n asynchronous, active low; clears handshake state and the line parser.
`default_nettype none
`include "assert_macros.svh"

module checked_command_line_parser_core #(
	parameter int MAX_KEY_CHARS = cclp_pkg::MAX_KEY_CHARS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_in,
	input  wire logic        last_char,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       frame_status,
	output logic [3:0]       command_code,
	output logic [63:0]      set_key,
	output logic [3:0]       set_key_length,
	output logic [15:0]      set_value
);

	localparam int KEY_W = 8 * MAX_KEY_CHARS;
	localparam int KCW = $clog2(MAX_KEY_CHARS + 2);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;
	logic        blocked;
	logic        proc;

	cclp_pkg::line_state_t st_q, st_n;
	logic [KEY_W-1:0]      key_q, key_n;
	logic [KCW-1:0]        kcnt_q, kcnt_n;
	cclp_pkg::result_t     res_n, res_q;
	logic                  out_valid_q;

	// A last beat cannot advance while a previous result is still held
	assign blocked = valid_s1 && last_s1 && out_valid_q && out_stall;
	assign in_stall = blocked;
	assign proc = valid_s1 && !blocked;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
			last_s1 <= last_char;
		end
	end

	cclp_step #(
		.MAX_KEY_CHARS(MAX_KEY_CHARS),
		.KEY_W(KEY_W),
		.KCW(KCW)
	) u_step (
		.st(st_q),
		.key_shift(key_q),
		.key_count(kcnt_q),
		.char_in(char_s1),
		.st_n(st_n),
		.key_shift_n(key_n),
		.key_count_n(kcnt_n)
	);

	cclp_eval #(
		.MAX_KEY_CHARS(MAX_KEY_CHARS),
		.KEY_W(KEY_W),
		.KCW(KCW)
	) u_eval (
		.st(st_n),
		.key_shift(key_n),
		.key_count(kcnt_n),
		.res(res_n)
	);

	// Line state: returns to its reset value after every last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cclp_pkg::state_reset();
			key_q <= '0;
			kcnt_q <= '0;
		end else if (proc) begin
			if (last_s1) begin
				st_q <= cclp_pkg::state_reset();
				key_q <= '0;
				kcnt_q <= '0;
			end else begin
				st_q <= st_n;
				key_q <= key_n;
				kcnt_q <= kcnt_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			res_q <= res_n;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_status = res_q.frame_status;
	assign command_code = res_q.command_code;
	assign set_key = res_q.set_key;
	assign set_key_length = res_q.set_key_length;
	assign set_value = res_q.set_value;

	`ASSERT_IMPLIES(a_result_from_last, clk, arst_n, out_valid_q && !$past(out_valid_q), $past(valid_s1 && last_s1), "result without a last beat")
	`ASSERT_IMPLIES(a_not_ok_zero, clk, arst_n, out_valid_q && res_q.frame_status != cclp_pkg::ST_OK, res_q.command_code == cclp_pkg::CMD_UNKNOWN && res_q.set_key == '0 && res_q.set_key_length == '0 && res_q.set_value == '0, "non-ok status carries fields")
	`ASSERT_IMPLIES(a_key_len_limit, clk, arst_n, out_valid_q, res_q.set_key_length <= 4'(MAX_KEY_CHARS), "key length over limit")
	`ASSERT_IMPLIES(a_set_has_key, clk, arst_n, out_valid_q && res_q.command_code == cclp_pkg::CMD_SET, res_q.set_key_length != '0, "SET without key")
	`ASSERT_NEXT(a_line_restart, clk, arst_n, proc && last_s1, st_q.phase == cclp_pkg::PH_SKIP && st_q.xor_sum == '0 && kcnt_q == '0, "state not cleared after line end")

endmodule

`default_nettype wire

### tb/sv/cmd_line_checker.sv
`default_nettype none

module cmd_line_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  char_in,
	input  wire logic        last_char,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  frame_status,
	input  wire logic [3:0]  command_code,
	input  wire logic [63:0] set_key,
	input  wire logic [3:0]  set_key_length,
	input  wire logic [15:0] set_value,
	output int               mismatches,
	output int               pending,
	output int               compared
);

	localparam logic [39:0] FRAME_HEAD = "@CMD,";
	localparam logic [31:0] SET_HEAD = "SET,";
	localparam int KEY_MAX = cclp_pkg::MAX_KEY_CHARS_DEF;

	// running line state of the predictor
	cclp_pkg::phase_t ph;
	logic [2:0]  head_idx;
	logic [7:0]  run_xor;
	logic [1:0]  nib_cnt;
	logic [7:0]  sum_rx;
	logic        sum_bad;
	logic [15:0] kw_live;
	logic [3:0]  body_len;
	logic [63:0] key_sr;
	logic [3:0]  key_len;
	logic [16:0] val_acc;
	logic        not_set;
	logic        seen_eq;
	logic        val_bad;
	logic        val_digit;

	// line results still owed by the block, oldest first
	cclp_pkg::result_t line_result_q[$];

	function automatic string word_text(input int k);
		string mode_pro;
		mode_pro = "MODE=PRO";
		case (k)
			0: return "STAT?";
			1: return "CFG?";
			2: return "LOG?";
			3: return "CLRLOG";
			4: return "LOGCLR";
			5: return "SAVE";
			6: return "RESET";
			7: return "DEFAULT";
			8: return {mode_pro, "_LITE"};
			9: return "MODE=LITE";
			10: return "DEMO=1";
			11: return "DEMO=ON";
			12: return "DEMO=0";
			13: return "DEMO=OFF";
			14: return mode_pro;
			default: return "MODE=BASIC";
		endcase
	endfunction

	function automatic logic [3:0] word_code(input int k);
		case (k)
			0: return cclp_pkg::CMD_STAT;
			1: return cclp_pkg::CMD_CFG;
			2: return cclp_pkg::CMD_LOG;
			3, 4: return cclp_pkg::CMD_CLRLOG;
			5: return cclp_pkg::CMD_SAVE;
			6, 7: return cclp_pkg::CMD_DEFAULT;
			8, 9: return cclp_pkg::CMD_MODE_LITE;
			10, 11: return cclp_pkg::CMD_DEMO_ON;
			12, 13: return cclp_pkg::CMD_DEMO_OFF;
			default: return cclp_pkg::CMD_MODE_PRO;
		endcase
	endfunction

	task automatic parse_clear();
		ph = cclp_pkg::PH_SKIP;
		head_idx = '0;
		run_xor = '0;
		nib_cnt = '0;
		sum_rx = '0;
		sum_bad = 1'b0;
		kw_live = '1;
		body_len = '0;
		key_sr = '0;
		key_len = '0;
		val_acc = '0;
		not_set = 1'b0;
		seen_eq = 1'b0;
		val_bad = 1'b0;
		val_digit = 1'b0;
	endtask

	// a well-formed SET wins; otherwise the first surviving keyword of full length
	function automatic cclp_pkg::result_t body_verdict();
		cclp_pkg::result_t r;
		string w;
		bit hit;
		r = '0;
		hit = 1'b0;
		if (body_len >= 4'd4 && !not_set && seen_eq && key_len >= 4'd1 && key_len <= KEY_MAX
				&& val_digit && !val_bad) begin
			r.command_code = cclp_pkg::CMD_SET;
			r.set_key = key_sr;
			r.set_key_length = key_len;
			r.set_value = val_acc[15:0];
		end else begin
			for (int k = 0; k < cclp_pkg::NUM_KW; k++) begin
				w = word_text(k);
				if (!hit && kw_live[k] && int'(body_len) == w.len()) begin
					r.command_code = word_code(k);
					hit = 1'b1;
				end
			end
		end
		return r;
	endfunction

	task automatic parse_byte(input logic [7:0] c, input logic fin);
		logic [4:0] nib;
		string w;
		int v;
		cclp_pkg::result_t r;

		if (ph == cclp_pkg::PH_SKIP && c != cclp_pkg::CH_SPACE && c != cclp_pkg::CH_TAB)
			ph = cclp_pkg::PH_PREFIX;

		case (ph)
			cclp_pkg::PH_PREFIX: begin
				if (head_idx < 3'd5 && c == FRAME_HEAD[39 - 8 * int'(head_idx) -: 8]) begin
					run_xor ^= c;
					head_idx++;
					if (head_idx == 3'd5)
						ph = cclp_pkg::PH_BODY;
				end else begin
					ph = cclp_pkg::PH_DEAD;
				end
			end
			cclp_pkg::PH_BODY: begin
				if (c == cclp_pkg::CH_STAR) begin
					ph = cclp_pkg::PH_HEX;
				end else begin
					run_xor ^= c;
					// keywords still matching at this position
					for (int k = 0; k < cclp_pkg::NUM_KW; k++) begin
						w = word_text(k);
						if (int'(body_len) >= w.len() || w[body_len] != c)
							kw_live[k] = 1'b0;
					end
					// SET header, then key up to '=', then decimal value
					if (body_len < 4'd4) begin
						if (c != SET_HEAD[31 - 8 * int'(body_len) -: 8])
							not_set = 1'b1;
					end else if (!seen_eq) begin
						if (c == cclp_pkg::CH_EQ) begin
							seen_eq = 1'b1;
						end else if (key_len <= KEY_MAX) begin
							key_len++;
							if (key_len <= KEY_MAX)
								key_sr = {key_sr[55:0], c};
						end
					end else if (c >= cclp_pkg::CH_0 && c <= cclp_pkg::CH_9) begin
						val_digit = 1'b1;
						v = int'(val_acc) * 10 + int'(c - cclp_pkg::CH_0);
						if (v > 65535) begin
							val_bad = 1'b1;
							val_acc = 17'd65536;
						end else begin
							val_acc = 17'(v);
						end
					end else begin
						val_bad = 1'b1;
					end
					if (body_len < 4'd15)
						body_len++;
				end
			end
			cclp_pkg::PH_HEX: begin
				if (nib_cnt < 2'd2) begin
					if (c >= cclp_pkg::CH_0 && c <= cclp_pkg::CH_9)
						nib = {1'b0, 4'(c - cclp_pkg::CH_0)};
					else if (c >= "A" && c <= "F")
						nib = {1'b0, 4'(c - "A" + 8'd10)};
					else if (c >= "a" && c <= "f")
						nib = {1'b0, 4'(c - "a" + 8'd10)};
					else
						nib = 5'h1F;
					sum_bad |= nib[4];
					sum_rx = {sum_rx[3:0], nib[3:0]};
					nib_cnt++;
				end
			end
			default: ;
		endcase

		// end of line: one result, then start over
		if (fin) begin
			r = '0;
			if (ph == cclp_pkg::PH_BODY) begin
				r = body_verdict();
			end else if (ph == cclp_pkg::PH_HEX) begin
				if (nib_cnt < 2'd2)
					r.frame_status = cclp_pkg::ST_BADFRAME;
				else if (sum_bad || sum_rx != run_xor)
					r.frame_status = cclp_pkg::ST_BADSUM;
				else
					r = body_verdict();
			end else begin
				r.frame_status = cclp_pkg::ST_NOCMD;
			end
			line_result_q.push_back(r);
			parse_clear();
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("line result %0d: %s expected %h got %h", compared, what, want, got);
		mismatches++;
	endtask

	// compare output beats first; an input beat never yields a result at the same edge
	always @(posedge clk or negedge arst_n) begin
		cclp_pkg::result_t want;
		if (!arst_n) begin
			parse_clear();
			line_result_q.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (line_result_q.size() == 0) begin
					flag_mismatch("result beat with no line pending", '0, '0);
				end else begin
					want = line_result_q.pop_front();
					if (frame_status !== want.frame_status)
						flag_mismatch("frame_status", want.frame_status, frame_status);
					if (command_code !== want.command_code)
						flag_mismatch("command_code", want.command_code, command_code);
					if (set_key !== want.set_key)
						flag_mismatch("set_key", want.set_key, set_key);
					if (set_key_length !== want.set_key_length)
						flag_mismatch("set_key_length", want.set_key_length, set_key_length);
					if (set_value !== want.set_value)
						flag_mismatch("set_value", want.set_value, set_value);
					compared++;
				end
			end
			if (in_valid && !in_stall)
				parse_byte(char_in, last_char);
			pending = line_result_q.size();
		end
	end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none

module tb_top;

	localparam int BYTE_TARGET = 1300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_in = 8'h00;
	logic        last_char = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  frame_status;
	logic [3:0]  command_code;
	logic [63:0] set_key;
	logic [3:0]  set_key_length;
	logic [15:0] set_value;

	int mismatches;
	int pending;
	int compared;
	int cycles = 0;
	int bytes_sent = 0;
	int lines_sent = 0;
	bit steady = 1'b0;

	// bytes of the line being built
	logic [7:0] line_q[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	checked_command_line_parser_core u_dut (
		.clk, .arst_n,
		.in_valid, .in_stall, .char_in, .last_char,
		.out_valid, .out_stall,
		.frame_status, .command_code, .set_key, .set_key_length, .set_value
	);

	cmd_line_checker u_check (
		.clk, .arst_n,
		.in_valid, .in_stall, .char_in, .last_char,
		.out_valid, .out_stall,
		.frame_status, .command_code, .set_key, .set_key_length, .set_value,
		.mismatches, .pending, .compared
	);

	// result side backpressure, off during the steady stretch
	always @(posedge clk)
		out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 27);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic string cmd_word(input int k);
		string mode_pro;
		mode_pro = "MODE=PRO";
		case (k)
			0: return "STAT?";
			1: return "CFG?";
			2: return "LOG?";
			3: return "CLRLOG";
			4: return "LOGCLR";
			5: return "SAVE";
			6: return "RESET";
			7: return "DEFAULT";
			8: return {mode_pro, "_LITE"};
			9: return "MODE=LITE";
			10: return "DEMO=1";
			11: return "DEMO=ON";
			12: return "DEMO=0";
			13: return "DEMO=OFF";
			14: return mode_pro;
			default: return "MODE=BASIC";
		endcase
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
		if (nib < 4'd10)
			return cclp_pkg::CH_0 + 8'(nib);
		return (lower ? "a" : "A") + 8'(nib) - 8'd10;
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	// one byte beat, with random idle cycles ahead of it outside the steady stretch
	task automatic send_beat(input logic [7:0] b, input logic fin);
		while (!steady && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= b;
		last_char <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_line();
		for (int i = 0; i < line_q.size(); i++)
			send_beat(line_q[i], i == line_q.size() - 1);
		line_q.delete();
		lines_sent++;
	endtask

	// hold the sender until every owed result has come out
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		int sel;
		int pick;
		int n;
		int start;
		logic [7:0] c;
		logic [7:0] sum;
		logic [7:0] ck;
		bit lower;
		bit starred;
		string s;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines: top byte value, end on '*', bad hex digits, plain command
		line_q.push_back(8'hFF);
		send_line();
		push_text(" \t@CMD,*");
		send_line();
		push_text("@CMD,LOG?*zz");
		send_line();
		push_text("@CMD,SAVE");
		send_line();
		drain();

		while (bytes_sent < BYTE_TARGET) begin
			steady <= (lines_sent >= 30 && lines_sent < 50);
			if (lines_sent % 20 == 0)
				drain();

			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3))
					line_q.push_back($urandom_range(0, 1) ? cclp_pkg::CH_SPACE
						: cclp_pkg::CH_TAB);

			sel = $urandom_range(0, 99);
			if (sel < 74) begin
				// framed line: prefix, body, then a checksum trailer or none
				start = line_q.size();
				push_text("@CMD,");
				if (sel < 38) begin
					s = cmd_word($urandom_range(0, 15));
					push_text(s);
					case ($urandom_range(0, 9))
						0: void'(line_q.pop_back());
						1: line_q.push_back(8'($urandom_range(32, 126)));
						2: line_q[line_q.size() - 1 - $urandom_range(0, s.len() - 1)] =
							8'($urandom_range(32, 126));
						default: ;
					endcase
				end else if (sel < 64) begin
					if ($urandom_range(0, 9) == 0)
						push_text("SeT,");
					else
						push_text("SET,");
					pick = $urandom_range(0, 19);
					n = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 14) : $urandom_range(1, 8);
					repeat (n) begin
						do c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
							: 8'($urandom_range(33, 126));
						while (c == cclp_pkg::CH_EQ || c == cclp_pkg::CH_STAR);
						line_q.push_back(c);
					end
					if ($urandom_range(0, 15) != 0)
						line_q.push_back(cclp_pkg::CH_EQ);
					case ($urandom_range(0, 11))
						0: s = "";
						1: s = "65535";
						2: s = "65536";
						3: s = "0";
						4: s = $sformatf("%0d", $urandom_range(65536, 9999999));
						5: begin
							c = $urandom_range(0, 1) ? "+" : "-";
							s = $sformatf("%c%0d", c, $urandom_range(0, 999));
						end
						6: s = $sformatf(" %0d", $urandom_range(0, 999));
						7: s = $sformatf("%0d%c", $urandom_range(0, 999), 8'($urandom_range(58, 126)));
						8: s = $sformatf("000%0d", $urandom_range(0, 65535));
						9: s = $sformatf("%0d", $urandom_range(65000, 65535));
						default: s = $sformatf("%0d", $urandom_range(0, 65535));
					endcase
					push_text(s);
				end else begin
					// raw body, may run past the length counter
					repeat ($urandom_range(0, 20))
						line_q.push_back(8'($urandom_range(0, 255)));
				end

				sum = 8'h00;
				starred = 1'b0;
				for (int i = start; i < line_q.size(); i++) begin
					if (!starred) begin
						if (line_q[i] == cclp_pkg::CH_STAR)
							starred = 1'b1;
						else
							sum ^= line_q[i];
					end
				end

				// trailer: good sum, wrong sum, bad digit, cut short, or none
				if (!starred) begin
					pick = $urandom_range(0, 99);
					lower = $urandom_range(0, 1);
					ck = (pick >= 45 && pick < 55) ? sum ^ 8'($urandom_range(1, 255)) : sum;
					if (pick < 72)
						line_q.push_back(cclp_pkg::CH_STAR);
					if (pick < 62) begin
						line_q.push_back(hex_char(ck[7:4], lower));
						line_q.push_back(hex_char(ck[3:0], lower));
					end else if (pick >= 67 && pick < 72) begin
						line_q.push_back(hex_char(ck[7:4], lower));
					end
					if (pick >= 55 && pick < 62) begin
						do c = 8'($urandom_range(0, 255));
						while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F")
							|| (c >= "a" && c <= "f"));
						line_q[line_q.size() - 1 - $urandom_range(0, 1)] = c;
					end
					if (pick < 62 && $urandom_range(0, 3) == 0)
						repeat ($urandom_range(1, 3))
							line_q.push_back(8'($urandom_range(0, 255)));
				end
			end else if (sel < 82) begin
				// cut or broken prefix
				s = "@CMD,";
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++)
					line_q.push_back(s[i]);
				if ($urandom_range(0, 1)) begin
					do c = 8'($urandom_range(0, 255)); while (c == s[n]);
					line_q.push_back(c);
					repeat ($urandom_range(0, 6))
						line_q.push_back(8'($urandom_range(0, 255)));
				end
			end else if (sel < 90) begin
				repeat ($urandom_range(1, 4))
					line_q.push_back($urandom_range(0, 1) ? cclp_pkg::CH_SPACE
						: cclp_pkg::CH_TAB);
				if ($urandom_range(0, 1))
					repeat ($urandom_range(1, 6))
						line_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 12))
					line_q.push_back(8'($urandom_range(0, 255)));
			end

			if (line_q.size() == 0)
				line_q.push_back(8'($urandom_range(0, 255)));
			send_line();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d bytes in %0d lines driven, %0d line results compared",
			bytes_sent, lines_sent, compared);
		$display("mix: keywords, SET key/value forms, checksum faults, prefix faults, noise");
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
